[rtl/mquh_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the multi-queue urgent head insert block.
// No dependencies; used by the top level.

package mquh_pkg;

	// Field widths fixed by the interface
	localparam int SEL_W    = 5;
	localparam int TAG_W    = 16;
	localparam int FILL_W   = 4;
	localparam int STATUS_W = 2;

	// Operation codes carried on the action field
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED  = 2'd0,
		ST_FULL   = 2'd1,
		ST_SERVED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_META,
		FSM_SLOT
	} fsm_t;

endpackage

[rtl/mquh_slot_ram.sv]
`timescale 1ns / 1ps
// Slot storage for all queue rings: one write port, one read port, registered read.
// No dependencies.

module mquh_slot_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 17
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data valid in the cycle after re
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/multi_queue_urgent_head_insert_core.sv]
`timescale 1ns / 1ps
// Bank of bounded queues with urgent head insert. Uses mquh_pkg, mquh_slot_ram.
// Result: registered from the metadata state, or from the slot state for a take
// that serves an entry. A new transaction is accepted only after the previous one's
// queue metadata read-modify-write (read at accept, written back in the metadata state).
// Reset: control and the per-queue metadata valid bits clear at once, so every
// queue reads empty with head 0; slot contents stay undefined, no clearing pass.

module multi_queue_urgent_head_insert_core #(
	parameter int QUEUE_DEPTH = 8,
	parameter int NUM_QUEUES  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [mquh_pkg::SEL_W-1:0]    queue_sel,
	input  logic [mquh_pkg::TAG_W-1:0]    entry_tag,
	input  logic                          urgent_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mquh_pkg::STATUS_W-1:0] status,
	output logic [mquh_pkg::TAG_W-1:0]    served_tag,
	output logic                          served_urgent,
	output logic [mquh_pkg::FILL_W-1:0]   fill_level
);

	localparam int PW     = $clog2(QUEUE_DEPTH);
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int QW     = $clog2(NUM_QUEUES);
	localparam int CMP_W  = ((QW > mquh_pkg::SEL_W) ? QW : mquh_pkg::SEL_W) + 1;
	localparam int MW     = PW + CW;
	localparam int SA_W   = QW + PW;
	localparam int SD_W   = mquh_pkg::TAG_W + 1;

	// Input decode
	logic [CMP_W-1:0] sel_ext;
	logic             sel_ok;
	logic [QW-1:0]    qidx_in;
	logic             in_acc;

	assign sel_ext = CMP_W'(queue_sel);
	assign sel_ok  = (sel_ext < CMP_W'(NUM_QUEUES));
	assign qidx_in = sel_ext[QW-1:0];
	assign in_acc  = in_valid && in_ready;

	// Captured transaction
	logic                       act_s1;
	logic                       ok_s1;
	logic [QW-1:0]              qidx_s1;
	logic [mquh_pkg::TAG_W-1:0] tag_s1;
	logic                       urg_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1  <= action;
			ok_s1   <= sel_ok;
			qidx_s1 <= qidx_in;
			tag_s1  <= entry_tag;
			urg_s1  <= urgent_in;
		end
	end

	// Queue metadata memory {head, count} with reset-cleared valid bits
	logic [MW-1:0]         meta_mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] meta_vld_q;
	logic [MW-1:0]         meta_rd_s1;
	logic                  meta_vld_s1;
	logic                  meta_we;
	logic [MW-1:0]         meta_wdata;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			meta_rd_s1  <= meta_mem[qidx_in];
			meta_vld_s1 <= meta_vld_q[qidx_in];
		end
		if (meta_we) begin
			meta_mem[qidx_s1] <= meta_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
		end else if (meta_we) begin
			meta_vld_q[qidx_s1] <= 1'b1;
		end
	end

	// Ring arithmetic on the fetched metadata
	logic [PW-1:0] head;
	logic [CW-1:0] cnt;
	logic          q_full;
	logic          q_empty;
	logic [PW:0]   tail_sum;
	logic [PW-1:0] tail_pos;
	logic [PW-1:0] head_dec;
	logic [PW-1:0] head_inc;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] cnt_dec;

	assign head     = meta_vld_s1 ? meta_rd_s1[MW-1:CW] : '0;
	assign cnt      = meta_vld_s1 ? meta_rd_s1[CW-1:0] : '0;
	assign q_full   = (cnt >= CW'(QUEUE_DEPTH));
	assign q_empty  = (cnt == '0);
	assign tail_sum = {1'b0, head} + (PW+1)'(cnt);
	assign tail_pos = (tail_sum >= (PW+1)'(QUEUE_DEPTH))
		? PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : tail_sum[PW-1:0];
	assign head_dec = (head == '0) ? PW'(QUEUE_DEPTH - 1) : head - PW'(1);
	assign head_inc = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
	assign cnt_inc  = cnt + CW'(1);
	assign cnt_dec  = cnt - CW'(1);

	// Slot storage
	logic            slot_we;
	logic            slot_re;
	logic [SA_W-1:0] slot_waddr;
	logic [SA_W-1:0] slot_raddr;
	logic [SD_W-1:0] slot_wdata;
	logic [SD_W-1:0] slot_rdata;

	assign slot_waddr = {qidx_s1, (urg_s1 ? head_dec : tail_pos)};
	assign slot_raddr = {qidx_s1, head};
	assign slot_wdata = {urg_s1, tag_s1};

	mquh_slot_ram #(
		.ADDR_W(SA_W),
		.DATA_W(SD_W)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (slot_re),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	// Fill level carried to the slot stage of a serving take
	logic [CW-1:0] fill_s2;

	always_ff @(posedge clk) begin
		if (slot_re) begin
			fill_s2 <= cnt_dec;
		end
	end

	// Result staged in the metadata cycle
	mquh_pkg::status_t meta_status;
	logic [CW-1:0]     meta_fill;
	logic              add_ok;
	logic              serve;

	assign add_ok = ok_s1 && (act_s1 == mquh_pkg::ACT_ADD) && !q_full;
	assign serve  = ok_s1 && (act_s1 == mquh_pkg::ACT_TAKE) && !q_empty;

	always_comb begin
		meta_status = mquh_pkg::ST_EMPTY;
		meta_fill   = cnt;
		priority if (!ok_s1) begin
			meta_status = (act_s1 == mquh_pkg::ACT_TAKE) ? mquh_pkg::ST_EMPTY
				: mquh_pkg::ST_FULL;
			meta_fill   = '0;
		end else if (act_s1 == mquh_pkg::ACT_ADD) begin
			meta_status = q_full ? mquh_pkg::ST_FULL : mquh_pkg::ST_ADDED;
			meta_fill   = q_full ? cnt : cnt_inc;
		end else begin
			meta_status = mquh_pkg::ST_EMPTY;
			meta_fill   = '0;
		end
	end

	assign meta_wdata = serve ? {head_inc, cnt_dec}
		: {(urg_s1 ? head_dec : head), cnt_inc};

	// Sequencer
	mquh_pkg::fsm_t state_q;
	mquh_pkg::fsm_t state_nxt;
	logic           out_valid_q;
	logic           can_load;
	logic           load_meta;
	logic           load_slot;

	assign can_load = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mquh_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		meta_we   = 1'b0;
		slot_we   = 1'b0;
		slot_re   = 1'b0;
		load_meta = 1'b0;
		load_slot = 1'b0;
		unique case (state_q)
			mquh_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = mquh_pkg::FSM_META;
				end
			end
			mquh_pkg::FSM_META: begin
				if (serve) begin
					meta_we   = 1'b1;
					slot_re   = 1'b1;
					state_nxt = mquh_pkg::FSM_SLOT;
				end else if (can_load) begin
					meta_we   = add_ok;
					slot_we   = add_ok;
					load_meta = 1'b1;
					state_nxt = mquh_pkg::FSM_IDLE;
				end
			end
			mquh_pkg::FSM_SLOT: begin
				if (can_load) begin
					load_slot = 1'b1;
					in_ready  = 1'b1;
					state_nxt = in_valid ? mquh_pkg::FSM_META : mquh_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_nxt = mquh_pkg::FSM_IDLE;
			end
		endcase
	end

	// Output register
	logic [mquh_pkg::STATUS_W-1:0] status_q;
	logic [mquh_pkg::TAG_W-1:0]    served_tag_q;
	logic                          served_urgent_q;
	logic [CW+3:0]                 fill_wide;
	logic [mquh_pkg::FILL_W-1:0]   fill_q;

	assign fill_wide = (CW+4)'(load_slot ? fill_s2 : meta_fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_meta || load_slot) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_meta) begin
			status_q        <= meta_status;
			served_tag_q    <= '0;
			served_urgent_q <= 1'b0;
			fill_q          <= fill_wide[mquh_pkg::FILL_W-1:0];
		end else if (load_slot) begin
			status_q        <= mquh_pkg::ST_SERVED;
			served_tag_q    <= slot_rdata[mquh_pkg::TAG_W-1:0];
			served_urgent_q <= slot_rdata[SD_W-1];
			fill_q          <= fill_wide[mquh_pkg::FILL_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign served_tag    = served_tag_q;
	assign served_urgent = served_urgent_q;
	assign fill_level    = fill_q;

endmodule
